// ===== rtl/rrdf_pkg.sv =====
`timescale 1ns / 1ps
package rrdf_pkg;

	localparam int unsigned TABLE_DEPTH = 16;

	typedef struct packed {
		logic [63:0] orig_hi;
		logic [63:0] orig_lo;
		logic [63:0] targ_hi;
		logic [63:0] targ_lo;
		logic [63:0] router_hi;
		logic [63:0] router_lo;
		logic [7:0]  prefix_len;
		logic [7:0]  metric_kind;
		logic [15:0] seqnum;
		logic [7:0]  metric;
	} req_t;

	// search token that walks the row of cells
	typedef struct packed {
		logic vld;
		logic stop;
		logic red;
		logic free_seen;
	} tok_t;

	typedef struct packed {
		logic clr;
		logic scan2;
		logic alloc;
	} ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN1,
		ST_SCAN2
	} state_t;

	localparam logic KIND_TICK = 1'b0;
	localparam logic [2:0] ADDR_LIFETIME = 3'd0;

endpackage

// ===== rtl/route_request_duplicate_filter.sv =====
`timescale 1ns / 1ps
// tick request: advances the tick counter, no result, busy stays low
// message request: done follows the first scan when that scan decides, or a
// second scan over the row of 16 cells when one is needed
// one request at a time; the token walks one cell per cycle in each scan
// done is a one-cycle strobe, the receiver cannot stall it
// arst_n clears the table valid bits and tick counter and sets the lifetime to 300
module route_request_duplicate_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [63:0] orig_prefix_hi,
	input  logic [63:0] orig_prefix_lo,
	input  logic [63:0] targ_prefix_hi,
	input  logic [63:0] targ_prefix_lo,
	input  logic [63:0] router_addr_hi,
	input  logic [63:0] router_addr_lo,
	input  logic [7:0]  orig_prefix_len,
	input  logic [7:0]  metric_kind,
	input  logic [15:0] origin_seq,
	input  logic [7:0]  route_metric,
	output logic        done,
	output logic        verdict,
	output logic        added,
	output logic        table_full,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned N = rrdf_pkg::TABLE_DEPTH;

	rrdf_pkg::state_t state_q, state_nxt;
	rrdf_pkg::req_t   req_q;
	rrdf_pkg::ctl_t   ctl;
	rrdf_pkg::tok_t   chain [N+1];

	logic [15:0] lifetime_q;
	logic [31:0] tick_q;
	logic [31:0] fresh;
	logic        start_q, scan2_go_q;
	logic        accept;
	// result register
	logic        done_q, verdict_q, added_q, full_q;
	logic        done_nxt, verdict_nxt, added_nxt, full_nxt, go2_nxt;

	assign pready = 1'b1;
	assign prdata = (paddr == rrdf_pkg::ADDR_LIFETIME) ? {16'd0, lifetime_q} : 32'd0;

	assign busy   = (state_q != rrdf_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign fresh  = tick_q + {16'd0, lifetime_q};

	// token enters cell 0 once per scan
	assign chain[0] = '{vld: start_q | scan2_go_q, stop: 1'b0, red: 1'b0, free_seen: 1'b0};

	// end of the row: a token that arrives here finishes the scan
	always_comb begin
		state_nxt   = state_q;
		done_nxt    = 1'b0;
		verdict_nxt = 1'b0;
		added_nxt   = 1'b0;
		full_nxt    = 1'b0;
		go2_nxt     = 1'b0;
		ctl.clr     = start_q;
		ctl.scan2   = (state_q == rrdf_pkg::ST_SCAN2);
		ctl.alloc   = 1'b0;
		case (state_q)
			rrdf_pkg::ST_IDLE: begin
				if (accept && (kind != rrdf_pkg::KIND_TICK)) begin
					state_nxt = rrdf_pkg::ST_SCAN1;
				end
			end
			rrdf_pkg::ST_SCAN1: begin
				if (chain[N].vld) begin
					if (chain[N].stop && !chain[N].red) begin
						// matched and updated: look for a no-worse compatible entry
						state_nxt = rrdf_pkg::ST_SCAN2;
						go2_nxt   = 1'b1;
					end else begin
						state_nxt   = rrdf_pkg::ST_IDLE;
						done_nxt    = 1'b1;
						verdict_nxt = chain[N].stop;
						// no match: claim the lowest free slot if any
						ctl.alloc   = !chain[N].stop && chain[N].free_seen;
						added_nxt   = !chain[N].stop && chain[N].free_seen;
						full_nxt    = !chain[N].stop && !chain[N].free_seen;
					end
				end
			end
			rrdf_pkg::ST_SCAN2: begin
				if (chain[N].vld) begin
					state_nxt   = rrdf_pkg::ST_IDLE;
					done_nxt    = 1'b1;
					verdict_nxt = chain[N].red;
				end
			end
			default: begin
				state_nxt = rrdf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rrdf_pkg::ST_IDLE;
			start_q    <= 1'b0;
			scan2_go_q <= 1'b0;
			done_q     <= 1'b0;
			tick_q     <= 32'd0;
			lifetime_q <= 16'd300;
		end else begin
			state_q    <= state_nxt;
			start_q    <= accept && (kind != rrdf_pkg::KIND_TICK);
			scan2_go_q <= go2_nxt;
			done_q     <= done_nxt;
			if (accept && (kind == rrdf_pkg::KIND_TICK)) begin
				tick_q <= tick_q + 32'd1;
			end
			if (psel && penable && pwrite && (paddr == rrdf_pkg::ADDR_LIFETIME)) begin
				lifetime_q <= pwdata[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		verdict_q <= verdict_nxt;
		added_q   <= added_nxt;
		full_q    <= full_nxt;
		if (accept) begin
			req_q <= '{orig_hi: orig_prefix_hi, orig_lo: orig_prefix_lo,
				targ_hi: targ_prefix_hi, targ_lo: targ_prefix_lo,
				router_hi: router_addr_hi, router_lo: router_addr_lo,
				prefix_len: orig_prefix_len, metric_kind: metric_kind,
				seqnum: origin_seq, metric: route_metric};
		end
	end

	// row of table cells, one entry each
	for (genvar i = 0; i < N; i++) begin : g_cell
		rrdf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.req     (req_q),
			.tick    (tick_q),
			.fresh   (fresh),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	assign done       = done_q;
	assign verdict    = verdict_q;
	assign added      = added_q;
	assign table_full = full_q;

endmodule

// ===== rtl/rrdf_cell.sv =====
`timescale 1ns / 1ps
module rrdf_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  rrdf_pkg::ctl_t  ctl,
	input  rrdf_pkg::req_t  req,
	input  logic [31:0]     tick,
	input  logic [31:0]     fresh,
	input  rrdf_pkg::tok_t  tok_in,
	output rrdf_pkg::tok_t  tok_out
);

	logic           valid_q;
	logic           hit_q;
	logic           cand_q;
	rrdf_pkg::req_t ent_q;
	logic [31:0]    dl_q;
	rrdf_pkg::tok_t tok_q;
	rrdf_pkg::tok_t tok_nxt;

	logic        stale, veff, key_eq, match, red1, proc, s1stop, s2stop;
	logic [15:0] d;

	always_comb begin
		stale  = valid_q && (tick >= dl_q);
		veff   = valid_q && !stale;
		key_eq = (ent_q.orig_hi == req.orig_hi) && (ent_q.orig_lo == req.orig_lo) &&
			(ent_q.targ_hi == req.targ_hi) && (ent_q.targ_lo == req.targ_lo) &&
			(ent_q.prefix_len == req.prefix_len) && (ent_q.metric_kind == req.metric_kind);
		match  = key_eq && (ent_q.router_hi == req.router_hi) &&
			(ent_q.router_lo == req.router_lo);
		d      = ent_q.seqnum - req.seqnum;
		// stored newer, or same number with a metric no worse
		red1   = ((d != 16'd0) && !d[15]) || ((d == 16'd0) && (ent_q.metric <= req.metric));
		proc   = tok_in.vld && !tok_in.stop;
		s1stop = proc && !ctl.scan2 && veff && match;
		s2stop = proc && ctl.scan2 && !hit_q && veff && key_eq && (ent_q.metric <= req.metric);
		tok_nxt = tok_in;
		if (s1stop) begin
			tok_nxt.stop = 1'b1;
			tok_nxt.red  = red1;
		end else if (s2stop) begin
			tok_nxt.stop = 1'b1;
			tok_nxt.red  = 1'b1;
		end else if (proc && !ctl.scan2 && !veff && !tok_in.free_seen) begin
			tok_nxt.free_seen = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
			cand_q  <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (ctl.clr) begin
				hit_q  <= 1'b0;
				cand_q <= 1'b0;
			end
			if (proc && stale) begin
				valid_q <= 1'b0;
			end
			if (s1stop) begin
				hit_q <= 1'b1;
			end
			if (proc && !ctl.scan2 && !veff && !tok_in.free_seen) begin
				cand_q <= 1'b1;
			end
			if (ctl.alloc && cand_q) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.alloc && cand_q) begin
			ent_q <= req;
			dl_q  <= fresh;
		end else if (s1stop) begin
			dl_q <= fresh;
			if (!red1) begin
				ent_q.seqnum <= req.seqnum;
				ent_q.metric <= req.metric;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== dv/route_request_duplicate_filter_tb.sv =====
`timescale 1ns / 1ps
module route_request_duplicate_filter_tb;

	// limit covers the worst message plus the random idle gap before each request
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic verdict;
		logic added;
		logic table_full;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        kind;
	logic [63:0] orig_prefix_hi;
	logic [63:0] orig_prefix_lo;
	logic [63:0] targ_prefix_hi;
	logic [63:0] targ_prefix_lo;
	logic [63:0] router_addr_hi;
	logic [63:0] router_addr_lo;
	logic [7:0]  orig_prefix_len;
	logic [7:0]  metric_kind;
	logic [15:0] origin_seq;
	logic [7:0]  route_metric;
	logic        done;
	logic        verdict;
	logic        added;
	logic        table_full;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// predicted table, mirrors the block's view of recent route requests
	rrdf_pkg::req_t dup_entry [rrdf_pkg::TABLE_DEPTH];
	bit             dup_valid [rrdf_pkg::TABLE_DEPTH];
	bit   [31:0]    dup_deadline [rrdf_pkg::TABLE_DEPTH];
	bit   [31:0]    now_ticks;
	bit   [15:0]    lifetime;

	verdict_t       pending_verdicts[$];
	int             fail_count;
	int             cycle_count;
	bit             no_idle;
	rrdf_pkg::req_t key_pool [8];

	route_request_duplicate_filter DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.orig_prefix_hi(orig_prefix_hi), .orig_prefix_lo(orig_prefix_lo),
		.targ_prefix_hi(targ_prefix_hi), .targ_prefix_lo(targ_prefix_lo),
		.router_addr_hi(router_addr_hi), .router_addr_lo(router_addr_lo),
		.orig_prefix_len(orig_prefix_len), .metric_kind(metric_kind),
		.origin_seq(origin_seq), .route_metric(route_metric),
		.done(done), .verdict(verdict), .added(added), .table_full(table_full),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog: a hung handshake or a lost result ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("route_request_duplicate_filter_tb: FAIL");
			$finish;
		end
	end

	// key match; the compatible check leaves out the router address
	function automatic bit same_key(input rrdf_pkg::req_t a, input rrdf_pkg::req_t b,
		input bit with_router);
		bit eq;
		eq = a.orig_hi == b.orig_hi && a.orig_lo == b.orig_lo &&
			a.targ_hi == b.targ_hi && a.targ_lo == b.targ_lo &&
			a.prefix_len == b.prefix_len && a.metric_kind == b.metric_kind;
		if (with_router)
			eq = eq && a.router_hi == b.router_hi && a.router_lo == b.router_lo;
		return eq;
	endfunction

	function automatic void drop_stale(input int i);
		if (dup_valid[i] && now_ticks >= dup_deadline[i])
			dup_valid[i] = 1'b0;
	endfunction

	// works out the outcome of one accepted request and queues it
	function automatic void filter_request(input logic k, input rrdf_pkg::req_t r);
		verdict_t    res;
		int          hit;
		logic [15:0] seq_gap;
		hit = -1;
		res = '{1'b0, 1'b0, 1'b0};
		if (k == rrdf_pkg::KIND_TICK) begin
			now_ticks = now_ticks + 1;
			return;
		end
		// first scan: clear stale entries up to the first match
		for (int i = 0; i < rrdf_pkg::TABLE_DEPTH; i++) begin
			drop_stale(i);
			if (dup_valid[i] && same_key(dup_entry[i], r, 1'b1)) begin
				hit = i;
				break;
			end
		end
		if (hit < 0) begin
			res.table_full = 1'b1;
			for (int i = 0; i < rrdf_pkg::TABLE_DEPTH; i++) begin
				if (!dup_valid[i]) begin
					dup_entry[i] = r;
					dup_deadline[i] = now_ticks + 32'(lifetime);
					dup_valid[i] = 1'b1;
					res.table_full = 1'b0;
					res.added = 1'b1;
					break;
				end
			end
			pending_verdicts.push_back(res);
			return;
		end
		dup_deadline[hit] = now_ticks + 32'(lifetime);
		// stored number newer when the wrapped distance is 1..0x7fff
		seq_gap = dup_entry[hit].seqnum - r.seqnum;
		if ((seq_gap != 16'h0 && seq_gap < 16'h8000) ||
			(seq_gap == 16'h0 && dup_entry[hit].metric <= r.metric)) begin
			res.verdict = 1'b1;
			pending_verdicts.push_back(res);
			return;
		end
		dup_entry[hit].seqnum = r.seqnum;
		dup_entry[hit].metric = r.metric;
		// second scan: another compatible entry with a metric no worse
		for (int i = 0; i < rrdf_pkg::TABLE_DEPTH; i++) begin
			drop_stale(i);
			if (i != hit && dup_valid[i] && same_key(dup_entry[i], r, 1'b0) &&
				dup_entry[i].metric <= r.metric) begin
				res.verdict = 1'b1;
				break;
			end
		end
		pending_verdicts.push_back(res);
	endfunction

	// result checker; the receiver cannot stall, so every done is taken
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				$error("result with no request outstanding");
				fail_count = fail_count + 1;
			end else begin
				want = pending_verdicts.pop_front();
				if (verdict !== want.verdict) begin
					$error("verdict expected %0b actual %0b", want.verdict, verdict);
					fail_count = fail_count + 1;
				end
				if (added !== want.added) begin
					$error("added expected %0b actual %0b", want.added, added);
					fail_count = fail_count + 1;
				end
				if (table_full !== want.table_full) begin
					$error("table_full expected %0b actual %0b", want.table_full,
						table_full);
					fail_count = fail_count + 1;
				end
			end
		end
	end

	// sends one request; start stays high when the next follows at once
	task automatic push_request(input logic k, input rrdf_pkg::req_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		orig_prefix_hi <= r.orig_hi;
		orig_prefix_lo <= r.orig_lo;
		targ_prefix_hi <= r.targ_hi;
		targ_prefix_lo <= r.targ_lo;
		router_addr_hi <= r.router_hi;
		router_addr_lo <= r.router_lo;
		orig_prefix_len <= r.prefix_len;
		metric_kind <= r.metric_kind;
		origin_seq <= r.seqnum;
		route_metric <= r.metric;
		do @(posedge clk); while (busy);
		filter_request(k, r);
	endtask

	task automatic send_msg(input rrdf_pkg::req_t r);
		push_request(~rrdf_pkg::KIND_TICK, r);
	endtask

	task automatic send_ticks(input int n);
		rrdf_pkg::req_t blank;
		blank = '0;
		repeat (n) push_request(rrdf_pkg::KIND_TICK, blank);
	endtask

	// sender holds off until every outstanding result has come back
	task automatic drain;
		start <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_lifetime(input bit [15:0] ticks);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= rrdf_pkg::ADDR_LIFETIME;
		pwdata <= 32'(ticks);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		lifetime = ticks;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic rrdf_pkg::req_t random_key;
		rrdf_pkg::req_t r;
		r.orig_hi = {$urandom, $urandom};
		r.orig_lo = {$urandom, $urandom};
		r.targ_hi = {$urandom, $urandom};
		r.targ_lo = {$urandom, $urandom};
		r.router_hi = {$urandom, $urandom};
		r.router_lo = {$urandom, $urandom};
		r.prefix_len = 8'($urandom_range(0, 128));
		r.metric_kind = 8'($urandom_range(0, 255));
		r.seqnum = 16'($urandom_range(0, 65535));
		r.metric = 8'($urandom_range(0, 255));
		return r;
	endfunction

	function automatic rrdf_pkg::req_t with_seq(input rrdf_pkg::req_t r, input bit [15:0] s,
		input bit [7:0] m);
		r.seqnum = s;
		r.metric = m;
		return r;
	endfunction

	// two prefix groups, four routers each, so compatible entries exist
	function automatic void refill_pool;
		rrdf_pkg::req_t base;
		for (int i = 0; i < 8; i++) begin
			if (i % 4 == 0)
				base = random_key();
			key_pool[i] = base;
			key_pool[i].router_hi = {$urandom, $urandom};
			key_pool[i].router_lo = {$urandom, $urandom};
		end
	endfunction

	// new entry, duplicates, metric and sequence updates, compatible redundancy
	task automatic test_basic_filtering;
		rrdf_pkg::req_t a, b, z, o;
		a = random_key();
		b = a;
		b.router_lo = ~a.router_lo;
		send_msg(with_seq(a, 10, 5));
		send_msg(with_seq(a, 10, 5));
		send_msg(with_seq(a, 10, 4));
		send_msg(with_seq(a, 9, 0));
		send_msg(with_seq(a, 11, 200));
		send_msg(with_seq(b, 1, 255));
		send_msg(with_seq(b, 2, 255));
		send_msg(with_seq(b, 3, 100));
		// all-zero and all-one keys at the field extremes
		z = '0;
		o = '1;
		o.prefix_len = 8'd128;
		send_msg(z);
		send_msg(z);
		send_msg(with_seq(o, 16'hffff, 8'hff));
		send_msg(with_seq(o, 16'h0000, 8'h00));
		send_ticks(2);
	endtask

	// half-way distance counts as the received number being newer
	task automatic test_seqnum_wrap;
		rrdf_pkg::req_t c;
		c = random_key();
		send_msg(with_seq(c, 16'h0000, 7));
		send_msg(with_seq(c, 16'h8000, 7));
		send_msg(with_seq(c, 16'h0000, 7));
		send_msg(with_seq(c, 16'h7fff, 7));
	endtask

	// short lifetime, entry goes stale and is taken again as new
	task automatic test_expiry;
		rrdf_pkg::req_t e;
		set_lifetime(16'd1);
		e = random_key();
		send_msg(e);
		send_msg(e);
		send_ticks(1);
		send_msg(e);
		set_lifetime(16'd3);
		send_msg(e);
		send_ticks(2);
		send_msg(e);
		send_ticks(1);
		send_msg(e);
	endtask

	// longest lifetime, more distinct keys than slots
	task automatic test_table_full;
		set_lifetime(16'hffff);
		repeat (rrdf_pkg::TABLE_DEPTH + 2) send_msg(random_key());
	endtask

	// mostly pooled keys so matches, updates and compatible hits are common
	task automatic test_random_traffic(input int n, input bit [15:0] ticks);
		rrdf_pkg::req_t r;
		int             roll;
		set_lifetime(ticks);
		refill_pool();
		for (int i = 0; i < n; i++) begin
			if (i % 25 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 25) begin
				send_ticks(1);
			end else if (roll < 85) begin
				r = key_pool[$urandom_range(0, 7)];
				r.seqnum = 16'($urandom_range(0, 3));
				if ($urandom_range(0, 9) == 0)
					r.seqnum = r.seqnum + 16'h8000;
				r.metric = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
					8'($urandom_range(0, 4));
				send_msg(r);
			end else begin
				send_msg(random_key());
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = 1'b0;
		{orig_prefix_hi, orig_prefix_lo, targ_prefix_hi, targ_prefix_lo} = '0;
		{router_addr_hi, router_addr_lo} = '0;
		orig_prefix_len = '0;
		metric_kind = '0;
		origin_seq = '0;
		route_metric = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		now_ticks = '0;
		lifetime = 16'd300;
		for (int i = 0; i < rrdf_pkg::TABLE_DEPTH; i++) begin
			dup_valid[i] = 1'b0;
			dup_entry[i] = '0;
			dup_deadline[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_filtering();
		test_seqnum_wrap();
		test_expiry();
		test_table_full();
		test_random_traffic(130, 16'd1);
		test_random_traffic(130, 16'd8);
		test_random_traffic(130, 16'd30);
		test_random_traffic(130, 16'hffff);
		test_random_traffic(130, 16'($urandom_range(2, 60)));

		drain();
		if (fail_count == 0)
			$display("route_request_duplicate_filter_tb: PASS");
		else
			$display("route_request_duplicate_filter_tb: FAIL");
		$finish;
	end

endmodule
